FILE: rtl/core/lsr_pkg.sv
// shared types and constants for the lfu slot replacement block
package lsr_pkg;

    // fixed field widths
    localparam int unsigned ID_W       = 7;
    localparam int unsigned ID_NUM     = 1 << ID_W;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned OUTC_W     = 2;
    localparam int unsigned SLOT_OUT_W = 5;
    localparam int unsigned CFG_W      = 6;
    localparam int unsigned APB_AW     = 2;
    localparam int unsigned APB_DW     = 32;

    // reset value of the active slot register
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = CFG_W'(32);

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTC_HIT     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FILL    = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_REPLACE = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_INC,
        S_SCAN,
        S_DONE
    } lsr_state_t;

    // control from the sequencer to the victim compare unit
    typedef struct packed {
        logic start;
        logic load;
    } cmp_ctrl_t;

endpackage

FILE: rtl/core/lsr_vram.sv
// ram with one read port and one write port and per-entry valid bits; entries never written read as zero
module lsr_vram
    import lsr_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned DW    = 39
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd_q_reg;
    logic             rd_valid_reg;

    // storage array write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entry reads as zero
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

FILE: rtl/core/lsr_victim_cmp.sv
// shared compare unit that tracks the victim slot over the scan
module lsr_victim_cmp
    import lsr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16,
    parameter int unsigned SLOT_W     = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmp_ctrl_t             ctrl,
    input  logic [COUNT_BITS-1:0] cand_cnt,
    input  logic [STAMP_W-1:0]    cand_order,
    input  logic [SLOT_W-1:0]     cand_slot,
    input  logic [ID_W-1:0]       cand_id,
    output logic                  best_vld,
    output logic [SLOT_W-1:0]     best_slot,
    output logic [ID_W-1:0]       best_id
);

    logic                  best_vld_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [STAMP_W-1:0]    best_order_reg;
    logic [SLOT_W-1:0]     best_slot_reg;
    logic [ID_W-1:0]       best_id_reg;
    logic                  take;

    // fewer references wins, then older stamp; equal keeps the lower slot
    always_comb
    begin
        take = ctrl.load &&
               (!best_vld_reg ||
                (best_cnt_reg > cand_cnt) ||
                ((best_cnt_reg == cand_cnt) && (best_order_reg > cand_order)));
    end

    // best-so-far flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_vld_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            best_vld_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            best_vld_reg <= 1'b1;
        end
    end

    // best-so-far payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_cnt_reg   <= cand_cnt;
            best_order_reg <= cand_order;
            best_slot_reg  <= cand_slot;
            best_id_reg    <= cand_id;
        end
    end

    assign best_vld  = best_vld_reg;
    assign best_slot = best_slot_reg;
    assign best_id   = best_id_reg;

endmodule

FILE: rtl/core/lfu_slot_replacement_top.sv
// lfu slot replacement: sequencer, config register and output register
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   ref_id
//  out       out  out_valid / out_ready outcome, slot_index, evicted_id
//  apb       in   psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// each item's time from accept to result is set by the slot scan over the n slots in use,
// which reads one slot per cycle through the slot ram with a count ram lookup
// behind it, plus the count increment and update; a hit or fill at slot j ends
// the scan there, and the next item is accepted once the sequencer is back in idle.
// reset clears all slots, counts and the stamp at once (valid bits).
// in_ready is high only while idle; a finished result waits in the output
// register and the next item can be accepted meanwhile.
module lfu_slot_replacement_top
    import lsr_pkg::*;
#(
    parameter int unsigned MAX_SLOTS  = 32,
    parameter int unsigned ID_SPACE   = 128,
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ID_W-1:0]       ref_id,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUTC_W-1:0]     outcome,
    output logic [SLOT_OUT_W-1:0] slot_index,
    output logic [ID_W-1:0]       evicted_id,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int unsigned CNT_DEPTH   = (ID_SPACE < ID_NUM) ? ID_SPACE : ID_NUM;
    localparam int unsigned CIDX_W      = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int unsigned SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned NCNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int unsigned SLOT_WORD_W = ID_W + STAMP_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [STAMP_W-1:0]    STAMP_MAX = '1;

    lsr_state_t state_reg, state_next;

    logic [CFG_W-1:0]      active_slots_reg;
    logic [STAMP_W-1:0]    insert_counter_reg;
    logic [ID_W-1:0]       id_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [NCNT_W-1:0]     n_reg;
    logic [NCNT_W-1:0]     n_eff;
    logic [NCNT_W-1:0]     rd_cnt_reg;
    logic                  a_vld_reg;
    logic [SLOT_W-1:0]     a_idx_reg;
    logic                  b_vld_reg;
    logic [SLOT_W-1:0]     b_idx_reg;
    logic [ID_W-1:0]       b_id_reg;
    logic [STAMP_W-1:0]    b_order_reg;
    logic [OUTC_W-1:0]     outcome_reg;
    logic [SLOT_W-1:0]     dst_reg;
    logic                  out_valid_reg;
    logic [OUTC_W-1:0]     outcome_out_reg;
    logic [SLOT_OUT_W-1:0] slot_out_reg;
    logic [ID_W-1:0]       evicted_out_reg;

    logic [CIDX_W-1:0]      mod_tab [ID_NUM];
    logic                   accept;
    logic                   out_free;
    logic                   cfg_wr;
    logic                   scan_issue;
    logic [SLOT_WORD_W-1:0] slot_rd_data;
    logic [ID_W-1:0]        slot_rd_id;
    logic [STAMP_W-1:0]     slot_rd_order;
    logic                   b_empty;
    logic                   b_hit;
    logic                   found;
    logic                   b_issue;
    logic                   scan_end;
    logic                   slot_wr_en;
    logic [SLOT_W-1:0]      dst_slot;
    logic                   cnt_rd_en;
    logic [CIDX_W-1:0]      cnt_rd_addr;
    logic [COUNT_BITS-1:0]  cnt_rd_data;
    logic                   cnt_wr_en;
    logic [CIDX_W-1:0]      cnt_wr_addr;
    logic [COUNT_BITS-1:0]  cnt_wr_data;
    logic [COUNT_BITS-1:0]  cnt_inc;
    cmp_ctrl_t              cmp_ctrl;
    logic                   best_vld;
    logic [SLOT_W-1:0]      best_slot;
    logic [ID_W-1:0]        best_id;
    logic [ID_W-1:0]        evicted_val;

    // identifier to count index table (id mod id space)
    for (genvar g = 0; g < ID_NUM; g++)
    begin : g_mod
        localparam int unsigned MV = g % ID_SPACE;
        assign mod_tab[g] = CIDX_W'(MV);
    end

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = APB_DW'(active_slots_reg);

    // handshakes
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // slots in use: zero acts as one, capped at the table size
    always_comb
    begin
        if (active_slots_reg == '0)
        begin
            n_eff = NCNT_W'(1);
        end
        else if (32'(active_slots_reg) > 32'(MAX_SLOTS))
        begin
            n_eff = NCNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_eff = NCNT_W'(active_slots_reg);
        end
    end

    // scan pipeline: slot read, then hit/empty check and count read
    assign slot_rd_id    = slot_rd_data[SLOT_WORD_W-1:STAMP_W];
    assign slot_rd_order = slot_rd_data[STAMP_W-1:0];
    assign scan_issue    = (state_reg == S_SCAN) && (rd_cnt_reg < n_reg);
    assign b_empty       = a_vld_reg && (slot_rd_id == '0);
    assign b_hit         = a_vld_reg && (slot_rd_id != '0) && (slot_rd_id == id_reg);
    assign found         = (state_reg == S_SCAN) && (b_empty || b_hit);
    assign b_issue       = (state_reg == S_SCAN) && a_vld_reg &&
                           (slot_rd_id != '0) && (slot_rd_id != id_reg);
    assign scan_end      = (state_reg == S_SCAN) && (rd_cnt_reg == n_reg) &&
                           !a_vld_reg && !b_vld_reg;

    // saturating reference count increment
    assign cnt_inc = (cnt_rd_data == CNT_MAX) ? cnt_rd_data
                                              : cnt_rd_data + COUNT_BITS'(1);

    // count ram port control
    always_comb
    begin
        cnt_rd_en   = accept || b_issue;
        cnt_rd_addr = accept ? mod_tab[ref_id] : mod_tab[slot_rd_id];
        cnt_wr_en   = (state_reg == S_INC) ||
                      ((state_reg == S_DONE) && (outcome_reg == OUTC_REPLACE));
        cnt_wr_addr = (state_reg == S_INC) ? mod_tab[id_reg] : mod_tab[best_id];
        cnt_wr_data = (state_reg == S_INC) ? cnt_inc : '0;
    end

    // slot update target and evicted identifier
    always_comb
    begin
        dst_slot    = (outcome_reg == OUTC_REPLACE) ? best_slot : dst_reg;
        evicted_val = (outcome_reg == OUTC_REPLACE) ? best_id : '0;
        slot_wr_en  = (state_reg == S_DONE) && (outcome_reg != OUTC_HIT);
    end

    // compare unit control
    always_comb
    begin
        cmp_ctrl.start = (state_reg == S_INC);
        cmp_ctrl.load  = (state_reg == S_SCAN) && b_vld_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (found || scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            active_slots_reg   <= ACTIVE_SLOTS_RST;
            insert_counter_reg <= '0;
            rd_cnt_reg         <= '0;
            a_vld_reg          <= 1'b0;
            b_vld_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_vld_reg <= scan_issue;
            b_vld_reg <= b_issue;
            if (cfg_wr)
            begin
                active_slots_reg <= pwdata[CFG_W-1:0];
            end
            if (accept && (insert_counter_reg != STAMP_MAX))
            begin
                insert_counter_reg <= insert_counter_reg + STAMP_W'(1);
            end
            if (state_reg == S_INC)
            begin
                rd_cnt_reg <= '0;
            end
            else if (scan_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + NCNT_W'(1);
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and scan pipeline registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= ref_id;
            stamp_reg <= insert_counter_reg;
            n_reg     <= n_eff;
        end
        a_idx_reg <= rd_cnt_reg[SLOT_W-1:0];
        if (b_issue)
        begin
            b_idx_reg   <= a_idx_reg;
            b_id_reg    <= slot_rd_id;
            b_order_reg <= slot_rd_order;
        end
        if (found)
        begin
            outcome_reg <= b_empty ? OUTC_FILL : OUTC_HIT;
            dst_reg     <= a_idx_reg;
        end
        else if (scan_end)
        begin
            outcome_reg <= OUTC_REPLACE;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            outcome_out_reg <= outcome_reg;
            slot_out_reg    <= SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, dst_slot});
            evicted_out_reg <= evicted_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign outcome    = outcome_out_reg;
    assign slot_index = slot_out_reg;
    assign evicted_id = evicted_out_reg;

    // slot table: identifier and insertion stamp per slot
    lsr_vram #(
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W),
        .DW    (SLOT_WORD_W)
    ) u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (scan_issue),
        .rd_addr (rd_cnt_reg[SLOT_W-1:0]),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (dst_slot),
        .wr_data ({id_reg, stamp_reg})
    );

    // reference counts per identifier
    lsr_vram #(
        .DEPTH (CNT_DEPTH),
        .AW    (CIDX_W),
        .DW    (COUNT_BITS)
    ) u_cnt_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data)
    );

    // victim selection
    lsr_victim_cmp #(
        .COUNT_BITS (COUNT_BITS),
        .SLOT_W     (SLOT_W)
    ) u_victim (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cmp_ctrl),
        .cand_cnt   (cnt_rd_data),
        .cand_order (b_order_reg),
        .cand_slot  (b_idx_reg),
        .cand_id    (b_id_reg),
        .best_vld   (best_vld),
        .best_slot  (best_slot),
        .best_id    (best_id)
    );

    // evicted id is zero unless a slot was replaced
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome != OUTC_REPLACE)) |-> (evicted_id == '0))
        else $error("evicted id set without replacement");

    // only defined outcome codes are delivered
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((outcome == OUTC_HIT) || (outcome == OUTC_FILL) ||
                       (outcome == OUTC_REPLACE)))
        else $error("undefined outcome code");

    // the updated slot lies within the slots in use
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (32'(dst_slot) < 32'(n_reg)))
        else $error("slot outside active range");

    // a replacement always has a victim candidate
    a_victim_seen: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (outcome_reg == OUTC_REPLACE)) |-> best_vld)
        else $error("replacement without victim");

    // the insertion stamp never goes backward
    a_stamp_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (insert_counter_reg >= $past(insert_counter_reg)))
        else $error("insertion stamp decreased");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the lfu slot replacement block with its own replacement predictor
module testbench;
    import lsr_pkg::*;

    localparam int unsigned SLOT_MAX         = 32;
    localparam logic [15:0] COUNT_SAT        = 16'hFFFF;
    localparam int unsigned REG_ACTIVE_SLOTS = 0;
    localparam int unsigned SCAN_SETTLE      = 40;
    localparam int unsigned CYCLE_LIMIT      = 3_000_000;
    localparam int unsigned HAMMER_LEN       = 40;
    localparam int unsigned SEG_ITEMS        = 200;
    localparam int unsigned MAX_REPORTS      = 40;

    typedef struct packed {
        logic [OUTC_W-1:0]     outcome;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       evicted;
    } lfu_result_t;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        bit              is_cfg;
        bit              typed;
        logic [ID_W-1:0] value;
        lfu_result_t     want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ID_W-1:0]       ref_id;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUTC_W-1:0]     outcome;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ID_W-1:0]       evicted_id;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // predictor copy of the slot table, counts, stamp and register
    logic [ID_W-1:0]    model_ids   [SLOT_MAX];
    logic [STAMP_W-1:0] model_stamp [SLOT_MAX];
    logic [15:0]        model_refs  [ID_NUM];
    logic [STAMP_W-1:0] model_clock;
    logic [CFG_W-1:0]   model_active;

    lfu_result_t awaited_slot_results[$];
    plan_row_t   plan[$];

    bit          in_idle;
    bit          out_idle;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned cfg_writes;
    int unsigned hits_seen;
    int unsigned fills_seen;
    int unsigned replaces_seen;
    int unsigned cycle_count;

    lfu_slot_replacement_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ref_id     (ref_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .slot_index (slot_index),
        .evicted_id (evicted_id),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // predict one reference: count update, scan for hit or empty, else lfu victim
    function automatic lfu_result_t lfu_access(input logic [ID_W-1:0] id);
        int unsigned n;
        int unsigned j;
        int unsigned v;
        bit          done;
        logic [15:0] cv;
        logic [15:0] cj;
        lfu_result_t r;
        n = (model_active == 0) ? 1 : ((model_active > SLOT_MAX) ? SLOT_MAX : model_active);
        r = '0;
        r.outcome = OUTC_REPLACE;
        done = 1'b0;
        if (model_refs[id] != COUNT_SAT)
            model_refs[id] = model_refs[id] + 16'd1;
        for (j = 0; j < n && !done; j++)
        begin
            if (model_ids[j] == '0)
            begin
                model_ids[j]   = id;
                model_stamp[j] = model_clock;
                r.outcome      = OUTC_FILL;
                r.slot         = SLOT_OUT_W'(j);
                done           = 1'b1;
            end
            else if (model_ids[j] == id)
            begin
                r.outcome = OUTC_HIT;
                r.slot    = SLOT_OUT_W'(j);
                done      = 1'b1;
            end
        end
        // fewest references wins, then oldest stamp, then lowest index
        if (!done)
        begin
            v = 0;
            for (j = 1; j < n; j++)
            begin
                cv = model_refs[model_ids[v]];
                cj = model_refs[model_ids[j]];
                if (cv > cj || (cv == cj && model_stamp[v] > model_stamp[j]))
                    v = j;
            end
            r.evicted                = model_ids[v];
            model_refs[model_ids[v]] = '0;
            model_ids[v]             = id;
            model_stamp[v]           = model_clock;
            r.slot                   = SLOT_OUT_W'(v);
        end
        if (model_clock != '1)
            model_clock = model_clock + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got %0d, want %0d",
                     results_seen, what, got, want);
    endtask

    // directed table rows
    task automatic add_item(input logic [ID_W-1:0] id);
        plan_row_t row;
        row = '0;
        row.value = id;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_item_typed(input logic [ID_W-1:0] id, input logic [OUTC_W-1:0] outc,
                                  input int unsigned slot, input logic [ID_W-1:0] ev);
        plan_row_t row;
        row = '0;
        row.typed        = 1'b1;
        row.value        = id;
        row.want.outcome = outc;
        row.want.slot    = SLOT_OUT_W'(slot);
        row.want.evicted = ev;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] value);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.value  = ID_W'(value);
        plan.insert(plan.size(), row);
    endtask

    // send one item; called and returns at a falling edge
    task automatic send_ref(input logic [ID_W-1:0] id, input bit typed, input lfu_result_t want);
        int unsigned gap;
        lfu_result_t predicted;
        gap = in_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ref_id   <= id;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predicted = lfu_access(id);
        awaited_slot_results.insert(awaited_slot_results.size(), typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // let all results drain and the scan settle before touching the register
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_slot_results.size() != 0)
            @(negedge clk);
        repeat (SCAN_SETTLE) @(negedge clk);
    endtask

    // apb write of active_slots followed by a readback
    task automatic write_active_slots(input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_ACTIVE_SLOTS);
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        model_active = value;
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(value))
            report_mismatch("active_slots readback", readback, APB_DW'(value));
    endtask

    // result side: random stalls, compare against the oldest prediction
    initial
    begin : result_check
        int unsigned gap;
        lfu_result_t want;
        @(negedge clk);
        forever
        begin
            gap = out_idle ? $urandom_range(0, 13) : 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            results_seen++;
            if (awaited_slot_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, outcome", 32'(outcome), 0);
            end
            else
            begin
                want = awaited_slot_results.pop_front();
                if (outcome !== want.outcome)
                    report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
                if (slot_index !== want.slot)
                    report_mismatch("slot_index", 32'(slot_index), 32'(want.slot));
                if (evicted_id !== want.evicted)
                    report_mismatch("evicted_id", 32'(evicted_id), 32'(want.evicted));
            end
            case (outcome)
                OUTC_HIT:     hits_seen++;
                OUTC_FILL:    fills_seen++;
                OUTC_REPLACE: replaces_seen++;
                default:      ;
            endcase
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned      seg;
        int unsigned      k;
        int unsigned      pick;
        int unsigned      n_eff;
        int unsigned      span;
        int unsigned      pool_base;
        logic [CFG_W-1:0] setting;
        logic [ID_W-1:0]  id;
        logic [CFG_W-1:0] seg_slots [10];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        ref_id    = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_idle   = 1'b1;
        out_idle  = 1'b1;
        for (k = 0; k < SLOT_MAX; k++)
        begin
            model_ids[k]   = '0;
            model_stamp[k] = '0;
        end
        for (k = 0; k < ID_NUM; k++)
            model_refs[k] = '0;
        model_clock  = '0;
        model_active = ACTIVE_SLOTS_RST;

        // directed table: fills after reset, identifier zero, ties, slot count extremes
        add_item_typed(7'd1,   OUTC_FILL, 0, 7'd0);
        add_item_typed(7'd1,   OUTC_HIT,  0, 7'd0);
        add_item_typed(7'd127, OUTC_FILL, 1, 7'd0);
        add_item_typed(7'd0,   OUTC_FILL, 2, 7'd0);
        add_item_typed(7'd0,   OUTC_FILL, 2, 7'd0);
        add_item_typed(7'd64,  OUTC_FILL, 2, 7'd0);
        add_cfg(6'd2);
        add_item_typed(7'd64,  OUTC_REPLACE, 1, 7'd127);
        add_item_typed(7'd0,   OUTC_REPLACE, 0, 7'd1);
        add_item_typed(7'd3,   OUTC_FILL,    0, 7'd0);
        add_cfg(6'd0);
        add_item_typed(7'd9,   OUTC_REPLACE, 0, 7'd3);
        add_item_typed(7'd9,   OUTC_HIT,     0, 7'd0);
        add_cfg(6'd63);
        add_item(7'd100);
        add_item(7'd64);
        add_cfg(6'd33);
        add_item(7'd127);
        add_cfg(6'd1);
        add_item_typed(7'd0,   OUTC_REPLACE, 0, 7'd9);
        add_item_typed(7'd42,  OUTC_FILL,    0, 7'd0);
        add_cfg(6'd32);
        add_item(7'd126);
        add_item(7'd85);
        add_item_typed(7'd42,  OUTC_HIT,     0, 7'd0);
        add_item(7'd127);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_active_slots(CFG_W'(plan[i].value));
            end
            else
            begin
                send_ref(plan[i].value, plan[i].typed, plan[i].want);
            end
        end
        wait_idle();

        // one slot, one identifier referenced back to back, no idling
        in_idle  = 1'b0;
        out_idle = 1'b0;
        write_active_slots(6'd1);
        for (k = 0; k < HAMMER_LEN; k++)
            send_ref(7'd77, 1'b0, '0);
        send_ref(7'd78, 1'b0, '0);
        send_ref(7'd77, 1'b0, '0);
        wait_idle();

        // random segments over several slot counts
        seg_slots = '{6'd32, 6'd1, 6'd5, 6'd2, 6'd16, 6'd31, 6'd0, 6'd63, 6'd8, 6'd20};
        for (seg = 0; seg < 10; seg++)
        begin
            setting  = (seg == 9) ? CFG_W'($urandom_range(1, 32)) : seg_slots[seg];
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            write_active_slots(setting);
            n_eff     = (setting == 0) ? 1 : ((setting > SLOT_MAX) ? SLOT_MAX : setting);
            pool_base = $urandom_range(0, 126);
            for (k = 0; k < SEG_ITEMS; k++)
            begin
                // shift the working set now and then to force evictions
                if ($urandom_range(0, 49) == 0)
                    pool_base = $urandom_range(0, 126);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    span = n_eff + $urandom_range(0, 4);
                    id   = ID_W'(((pool_base + $urandom_range(0, span - 1)) % 127) + 1);
                end
                else if (pick < 78)
                begin
                    id = '0;
                end
                else
                begin
                    id = ID_W'($urandom_range(0, 127));
                end
                send_ref(id, 1'b0, '0);
            end
            wait_idle();
        end

        $display("ran %0d items across %0d active_slots writes (0, 1, 2, 32, 33, 63 among them)",
                 items_sent, cfg_writes);
        $display("seen %0d hits, %0d fills, %0d replacements; %0d mismatches",
                 hits_seen, fills_seen, replaces_seen, mismatches);
        if (mismatches == 0 && awaited_slot_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
